// File: rtl/fsa_pkg.sv
package fsa_pkg;

  localparam int LIMIT_W = 17;
  localparam int WASTE_W = 16;
  localparam int CFG_DW = 17;
  localparam int CFG_IW = 1;
  localparam int STATUS_W = 2;

  localparam logic [CFG_IW-1:0] CFG_HEAP_LIMIT = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_WASTE_LIMIT = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = 17'h10000;
  localparam logic [WASTE_W-1:0] WASTE_LIMIT_RST = 16'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_ROT  = 3'd1,
    CELL_WR   = 3'd2,
    CELL_INS  = 3'd3,
    CELL_DEL  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     a_used;
  } cell_ctl_t;

endpackage

// File: rtl/fsa_req_if.sv
interface fsa_req_if #(parameter int OFFSET_WIDTH = 16);
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [OFFSET_WIDTH-1:0] req_size;
  logic [OFFSET_WIDTH-1:0] req_offset;

  modport source (output valid, output op, output req_size, output req_offset, input ready);
  modport sink (input valid, input op, input req_size, input req_offset, output ready);
endinterface

// File: rtl/fsa_rsp_if.sv
interface fsa_rsp_if #(parameter int OFFSET_WIDTH = 16);
  logic                    valid;
  logic                    ready;
  logic [OFFSET_WIDTH-1:0] grant_offset;
  logic [1:0]              status;

  modport source (output valid, output grant_offset, output status, input ready);
  modport sink (input valid, input grant_offset, input status, output ready);
endinterface

// File: rtl/fsa_cell.sv
module fsa_cell
  import fsa_pkg::*;
#(
  parameter int IW = 6,
  parameter int OW = 16,
  parameter int K = 0
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [IW-1:0] idx,
  input  logic [OW-1:0] a_size,
  input  logic [OW-1:0] b_size,
  input  logic [OW-1:0] left_size,
  input  logic          left_used,
  input  logic [OW-1:0] right_size,
  input  logic          right_used,
  output logic [OW-1:0] size,
  output logic          used
);

  localparam logic [IW:0] KX = (IW+1)'(K);

  logic [IW:0] idx_x;
  logic [IW:0] idx_p1;

  assign idx_x = {1'b0, idx};
  assign idx_p1 = idx_x + 1'b1;

  // Rotation walks the table past cell 0; insert and delete open or close a gap.
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_ROT: begin
        size <= right_size;
        used <= right_used;
      end
      CELL_WR: begin
        if (KX == idx_x) begin
          size <= a_size;
          used <= ctl.a_used;
        end
      end
      CELL_INS: begin
        if (KX == idx_x) begin
          size <= a_size;
          used <= ctl.a_used;
        end else if (KX == idx_p1) begin
          size <= b_size;
          used <= 1'b0;
        end else if (KX > idx_p1) begin
          size <= left_size;
          used <= left_used;
        end
      end
      CELL_DEL: begin
        if (KX > idx_x) begin
          size <= right_size;
          used <= right_used;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/first_fit_segment_allocator_unit.sv
// An accepted request beat rotates the whole segment cell chain past cell 0 in S_SCAN,
// then S_DECIDE picks the result; a table write passes through S_FIN, and a merge of
// free neighbours first deletes the absorbed segments in S_DEL. S_DONE then issues the
// result beat, held back by any result stall. A new request is taken only once the
// previous result has been issued, as the full rotation of the chain runs per request.
// Reset clears the segment count, the heap top and the result valid, and loads the
// default limits; the segment cells themselves are not cleared.
module first_fit_segment_allocator_unit
  import fsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int OFFSET_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data,
  fsa_req_if.sink            req,
  fsa_rsp_if.source          rsp
);

  localparam int N = MAX_SEGMENTS;
  localparam int OW = OFFSET_WIDTH;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int AW = ((OW > LIMIT_W) ? OW : LIMIT_W) + 2;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_DEL    = 6'b001000,
    S_FIN    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;

  logic [LIMIT_W-1:0] heap_limit;
  logic [WASTE_W-1:0] waste_limit;
  logic [CW-1:0]      seg_count;
  logic [OW:0]        heap_top;

  logic               op_q;
  logic [OW-1:0]      req_q;
  logic [OW-1:0]      roff_q;
  logic [IW-1:0]      ctr;
  logic [OW:0]        off;

  logic               ff_found;
  logic [IW-1:0]      ff_idx;
  logic [OW:0]        ff_off;
  logic [OW-1:0]      ff_size;

  logic               run;
  logic [IW-1:0]      run_s;
  logic [OW:0]        run_off;
  logic [OW:0]        run_sum;
  logic               mg_found;
  logic [IW-1:0]      mg_i;

  logic               fm_found;
  logic [IW-1:0]      fm_idx;
  logic [OW-1:0]      fm_size;
  logic               lu_v;
  logic [IW-1:0]      lu_k;
  logic [OW:0]        lu_end;

  cell_op_t           fin_op;
  logic [IW-1:0]      fin_idx;
  logic [OW-1:0]      fin_a_size;
  logic               fin_a_used;
  logic [OW-1:0]      fin_b_size;
  logic [IW-1:0]      del_left;

  logic [OW-1:0]      res_off;
  status_t            res_status;
  logic               rsp_valid;
  logic [OW-1:0]      rsp_off;
  status_t            rsp_status;

  logic [OW-1:0]      sz [N];
  logic               us [N];

  cell_ctl_t          ctl;
  logic [IW-1:0]      ctl_idx;
  logic [OW-1:0]      ctl_a_size;
  logic [OW-1:0]      ctl_b_size;

  // Scan of the entry currently sitting in cell 0.
  logic               live;
  logic [OW:0]        off_add;
  logic [OW:0]        run_add;
  logic               ff_hit;
  logic               fm_hit;

  assign live = CW'(ctr) < seg_count;
  assign off_add = off + (OW+1)'(sz[0]);
  assign run_add = run_sum + (OW+1)'(sz[0]);
  assign ff_hit = live && !ff_found && !us[0] && (sz[0] >= req_q);
  assign fm_hit = live && !fm_found && (off == {1'b0, roff_q});

  // Decision terms.
  logic [AW-1:0]      lim_a;
  logic [AW-1:0]      cap_a;
  logic [AW-1:0]      lim_eff;
  logic               fits;
  logic               split_ff;
  logic               split_mg;
  logic [IW-1:0]      gap;

  assign lim_a = AW'(heap_limit);
  assign cap_a = AW'(1) << OW;
  assign lim_eff = (lim_a < cap_a) ? lim_a : cap_a;
  assign fits = (AW'(heap_top) + AW'(req_q)) < lim_eff;
  assign split_ff = (AW'(ff_size) > (AW'(waste_limit) + AW'(req_q)))
                    && (seg_count < CW'(N));
  assign split_mg = AW'(run_sum) > (AW'(waste_limit) + AW'(req_q));
  assign gap = mg_i - run_s;

  always_comb begin
    ctl.op = CELL_HOLD;
    ctl.a_used = fin_a_used;
    ctl_idx = fin_idx;
    ctl_a_size = fin_a_size;
    ctl_b_size = fin_b_size;
    case (state)
      S_SCAN: ctl.op = CELL_ROT;
      S_DEL: begin
        ctl.op = CELL_DEL;
        ctl_idx = run_s;
      end
      S_FIN: ctl.op = fin_op;
      default: ctl.op = CELL_HOLD;
    endcase
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam int L = (k == 0) ? 0 : k - 1;
    localparam int R = (k == N - 1) ? 0 : k + 1;
    fsa_cell #(
      .IW(IW),
      .OW(OW),
      .K (k)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (ctl_idx),
      .a_size    (ctl_a_size),
      .b_size    (ctl_b_size),
      .left_size (sz[L]),
      .left_used (us[L]),
      .right_size(sz[R]),
      .right_used(us[R]),
      .size      (sz[k]),
      .used      (us[k])
    );
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.grant_offset = rsp_off;
  assign rsp.status = rsp_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= HEAP_LIMIT_RST;
      waste_limit <= WASTE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAP_LIMIT: heap_limit <= cfg_data;
        CFG_WASTE_LIMIT: waste_limit <= cfg_data[WASTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seg_count <= '0;
      heap_top <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q <= req.op;
            req_q <= req.req_size;
            roff_q <= req.req_offset;
            ctr <= '0;
            off <= '0;
            ff_found <= 1'b0;
            run <= 1'b0;
            run_sum <= '0;
            mg_found <= 1'b0;
            fm_found <= 1'b0;
            lu_v <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          off <= off_add;
          ctr <= ctr + 1'b1;
          if (ff_hit) begin
            ff_found <= 1'b1;
            ff_idx <= ctr;
            ff_off <= off;
            ff_size <= sz[0];
          end
          if (fm_hit) begin
            fm_found <= 1'b1;
            fm_idx <= ctr;
            fm_size <= sz[0];
          end
          if (live && us[0] && !fm_hit) begin
            lu_v <= 1'b1;
            lu_k <= ctr;
            lu_end <= off_add;
          end
          // A run of free entries only counts once it spans two or more.
          if (live && !mg_found) begin
            if (us[0]) begin
              run <= 1'b0;
            end else if (!run) begin
              run <= 1'b1;
              run_s <= ctr;
              run_sum <= (OW+1)'(sz[0]);
              run_off <= off;
            end else begin
              run_sum <= run_add;
              if (run_add >= (OW+1)'(req_q)) begin
                mg_found <= 1'b1;
                mg_i <= ctr;
              end
            end
          end
          if (ctr == IW'(N - 1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (op_q == OP_FREE) begin
            res_off <= '0;
            if (fm_found) begin
              res_status <= ST_OK;
              fin_op <= CELL_WR;
              fin_idx <= fm_idx;
              fin_a_size <= fm_size;
              fin_a_used <= 1'b0;
              seg_count <= lu_v ? (CW'(lu_k) + 1'b1) : '0;
              heap_top <= lu_v ? lu_end : '0;
              state <= S_FIN;
            end else begin
              res_status <= ST_NOMATCH;
              state <= S_DONE;
            end
          end else if (ff_found) begin
            fin_idx <= ff_idx;
            fin_a_used <= 1'b1;
            res_off <= ff_off[OW-1:0];
            res_status <= ST_OK;
            if (split_ff) begin
              fin_op <= CELL_INS;
              fin_a_size <= req_q;
              fin_b_size <= ff_size - req_q;
              seg_count <= seg_count + 1'b1;
            end else begin
              fin_op <= CELL_WR;
              fin_a_size <= ff_size;
            end
            state <= S_FIN;
          end else if (fits) begin
            if (seg_count >= CW'(N)) begin
              res_off <= '0;
              res_status <= ST_FULL;
              state <= S_DONE;
            end else begin
              fin_op <= CELL_WR;
              fin_idx <= seg_count[IW-1:0];
              fin_a_size <= req_q;
              fin_a_used <= 1'b1;
              seg_count <= seg_count + 1'b1;
              heap_top <= heap_top + (OW+1)'(req_q);
              res_off <= heap_top[OW-1:0];
              res_status <= ST_OK;
              state <= S_FIN;
            end
          end else if (mg_found) begin
            fin_idx <= run_s;
            fin_a_used <= 1'b1;
            del_left <= gap;
            res_off <= run_off[OW-1:0];
            res_status <= ST_OK;
            if (split_mg) begin
              fin_op <= CELL_INS;
              fin_a_size <= req_q;
              fin_b_size <= run_sum[OW-1:0] - req_q;
              seg_count <= seg_count - CW'(gap) + 1'b1;
            end else begin
              fin_op <= CELL_WR;
              fin_a_size <= run_sum[OW-1:0];
              seg_count <= seg_count - CW'(gap);
            end
            state <= S_DEL;
          end else begin
            res_off <= '0;
            res_status <= ST_OOM;
            state <= S_DONE;
          end
        end
        S_DEL: begin
          del_left <= del_left - 1'b1;
          if (del_left == IW'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_off <= res_off;
            rsp_status <= res_status;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    seg_count <= CW'(N))
    else $error("segment count exceeds table depth");

  a_top_fits: assert property (@(posedge clk) disable iff (rst)
    heap_top[OW] == 1'b0)
    else $error("heap top outside offset range");

  a_accept_scans: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_SCAN && ctr == '0))
    else $error("accepted request did not start a scan");

  a_del_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEL) |-> (del_left != '0))
    else $error("merge delete count underflow");

endmodule
